// File: sv/deq_pkg.sv
`default_nettype none
package deq_pkg;

	localparam int DEPTH = 1024;
	localparam int DATA_W = 32;
	localparam int REQ_W = 3;
	localparam int COUNT_W = 11;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

	localparam logic signed [DATA_W-1:0] NEG_ONE = -32'sd1;

	// data move along one row
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_SHIFT_IN,
		OP_SHIFT_OUT,
		OP_APPEND
	} chain_op_t;

	// occupancy move, valid bits form a thermometer
	typedef enum logic [1:0] {
		V_HOLD,
		V_GROW,
		V_SHRINK
	} vld_op_t;

	typedef struct packed {
		chain_op_t f_op;
		chain_op_t b_op;
		vld_op_t   v_op;
	} cell_ctl_t;

	// f: front-aligned copy, b: back-aligned copy
	typedef struct packed {
		logic              v;
		logic [DATA_W-1:0] f;
		logic [DATA_W-1:0] b;
	} cell_t;

endpackage
`default_nettype wire

// File: sv/deq_if.sv
`default_nettype none
interface deq_req_if;
	logic                                valid;
	logic                                ready;
	logic [deq_pkg::REQ_W-1:0]           req_type;
	logic signed [deq_pkg::DATA_W-1:0]   push_value;

	modport source(output valid, req_type, push_value, input ready);
	modport sink(input valid, req_type, push_value, output ready);
endinterface

interface deq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [deq_pkg::DATA_W-1:0]   popped_value;
	logic [deq_pkg::COUNT_W-1:0]         entry_count;
	logic                                is_empty;
	logic signed [deq_pkg::DATA_W-1:0]   front_value;
	logic signed [deq_pkg::DATA_W-1:0]   back_value;
	logic                                push_dropped;

	modport source(output valid, popped_value, entry_count, is_empty, front_value,
		back_value, push_dropped, input ready);
	modport sink(input valid, popped_value, entry_count, is_empty, front_value,
		back_value, push_dropped, output ready);
endinterface
`default_nettype wire

// File: sv/deq_cell.sv
`default_nettype none
module deq_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire deq_pkg::cell_ctl_t          ctl,
	input  wire logic [deq_pkg::DATA_W-1:0]  push_value,
	input  wire deq_pkg::cell_t              prev,
	input  wire deq_pkg::cell_t              nxt,
	output deq_pkg::cell_t                   state
);

	logic                        v_q;
	logic [deq_pkg::DATA_W-1:0]  f_q;
	logic [deq_pkg::DATA_W-1:0]  b_q;
	logic                        v_d;
	logic [deq_pkg::DATA_W-1:0]  f_d;
	logic [deq_pkg::DATA_W-1:0]  b_d;

	always_comb begin
		case (ctl.v_op)
			deq_pkg::V_GROW:   v_d = prev.v;
			deq_pkg::V_SHRINK: v_d = nxt.v;
			default:           v_d = v_q;
		endcase
	end

	// append: contents of empty cells are don't-care, so every empty cell loads
	always_comb begin
		case (ctl.f_op)
			deq_pkg::OP_SHIFT_IN:  f_d = prev.f;
			deq_pkg::OP_SHIFT_OUT: f_d = nxt.f;
			deq_pkg::OP_APPEND:    f_d = v_q ? f_q : push_value;
			default:               f_d = f_q;
		endcase
	end

	always_comb begin
		case (ctl.b_op)
			deq_pkg::OP_SHIFT_IN:  b_d = prev.b;
			deq_pkg::OP_SHIFT_OUT: b_d = nxt.b;
			deq_pkg::OP_APPEND:    b_d = v_q ? b_q : push_value;
			default:               b_d = b_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		f_q <= f_d;
		b_q <= b_d;
	end

	assign state = '{v: v_q, f: f_q, b: b_q};

endmodule
`default_nettype wire

// File: sv/deq_row.sv
`default_nettype none
module deq_row (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire deq_pkg::cell_ctl_t          ctl,
	input  wire logic [deq_pkg::DATA_W-1:0]  push_value,
	output deq_pkg::cell_t                   head
);

	deq_pkg::cell_t st [deq_pkg::DEPTH];
	deq_pkg::cell_t lhs [deq_pkg::DEPTH];
	deq_pkg::cell_t rhs [deq_pkg::DEPTH];

	genvar gi;
	generate
		for (gi = 0; gi < deq_pkg::DEPTH; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				// a new entry enters from beyond the head
				assign lhs[gi] = '{v: 1'b1, f: push_value, b: push_value};
			end else begin : g_mid
				assign lhs[gi] = st[gi-1];
			end
			if (gi == deq_pkg::DEPTH - 1) begin : g_last
				assign rhs[gi] = '{v: 1'b0, f: '0, b: '0};
			end else begin : g_inner
				assign rhs[gi] = st[gi+1];
			end
			deq_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.push_value (push_value),
				.prev       (lhs[gi]),
				.nxt        (rhs[gi]),
				.state      (st[gi])
			);
		end
	endgenerate

	assign head = st[0];

endmodule
`default_nettype wire

// File: sv/double_ended_queue_top.sv
// Double-ended queue of signed 32-bit items, 1024 entries, built as a row of cells.
// A request is applied to the row and held in stage 1; its result then goes to the
// result register (stage 2), which holds it while rsp.ready is low.
// Throughput: one request per cycle unless rsp.ready stalls; rows shift at once.
// Reset (arst_n low, asynchronous): queue empty, both pipeline stages empty.
// Entry data is not reset; only the per-cell occupancy bits are.
`default_nettype none
module double_ended_queue_top (
	input  wire logic   clk,
	input  wire logic   arst_n,
	deq_req_if.sink     req,
	deq_rsp_if.source   rsp
);

	// Each entry is held twice: once in a row aligned to the front
	// (cell 0 = front) and once in a row aligned to the back (cell 0 = back). Every
	// operation is then a shift or a local load, and both ends are read from
	// cell 0 only.

	deq_pkg::cell_ctl_t          ctl;
	deq_pkg::cell_t              head;

	logic [deq_pkg::CNT_W-1:0]   count_q;
	logic [deq_pkg::CNT_W-1:0]   count_d;
	logic                        accept;
	logic                        full;
	logic                        empty;
	logic                        out_free;

	logic [deq_pkg::DATA_W-1:0]  popped_d;
	logic                        dropped_d;

	// stage 1: request applied to the row, side results held here
	logic                        valid_s1;
	logic [deq_pkg::DATA_W-1:0]  popped_s1;
	logic                        dropped_s1;

	// stage 2: result register
	logic                        out_valid_q;
	logic [deq_pkg::DATA_W-1:0]  popped_q;
	logic [deq_pkg::COUNT_W-1:0] entry_count_q;
	logic                        is_empty_q;
	logic [deq_pkg::DATA_W-1:0]  front_q;
	logic [deq_pkg::DATA_W-1:0]  back_q;
	logic                        dropped_q;

	assign out_free  = !out_valid_q || rsp.ready;
	// row state must stay put while stage 1 waits to read it
	assign req.ready = !valid_s1 || out_free;
	assign accept    = req.valid && req.ready;

	assign full  = count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH);
	assign empty = count_q == '0;

	always_comb begin
		ctl       = '{f_op: deq_pkg::OP_HOLD, b_op: deq_pkg::OP_HOLD, v_op: deq_pkg::V_HOLD};
		count_d   = count_q;
		popped_d  = deq_pkg::NEG_ONE;
		dropped_d = 1'b0;
		if (accept) begin
			case (req.req_type)
				deq_pkg::REQ_PUSH_FRONT: begin
					if (full) begin
						dropped_d = 1'b1;
					end else begin
						ctl     = '{f_op: deq_pkg::OP_SHIFT_IN, b_op: deq_pkg::OP_APPEND,
							v_op: deq_pkg::V_GROW};
						count_d = count_q + 1'b1;
					end
				end
				deq_pkg::REQ_PUSH_BACK: begin
					if (full) begin
						dropped_d = 1'b1;
					end else begin
						ctl     = '{f_op: deq_pkg::OP_APPEND, b_op: deq_pkg::OP_SHIFT_IN,
							v_op: deq_pkg::V_GROW};
						count_d = count_q + 1'b1;
					end
				end
				deq_pkg::REQ_POP_FRONT: begin
					if (!empty) begin
						// back row only loses its last occupied cell
						ctl      = '{f_op: deq_pkg::OP_SHIFT_OUT, b_op: deq_pkg::OP_HOLD,
							v_op: deq_pkg::V_SHRINK};
						count_d  = count_q - 1'b1;
						popped_d = head.f;
					end
				end
				deq_pkg::REQ_POP_BACK: begin
					if (!empty) begin
						ctl      = '{f_op: deq_pkg::OP_HOLD, b_op: deq_pkg::OP_SHIFT_OUT,
							v_op: deq_pkg::V_SHRINK};
						count_d  = count_q - 1'b1;
						popped_d = head.b;
					end
				end
				default: begin
					// query, and unused codes
				end
			endcase
		end
	end

	deq_row u_row (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.push_value (req.push_value),
		.head       (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (out_free) begin
				valid_s1 <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			popped_s1  <= popped_d;
			dropped_s1 <= dropped_d;
		end
		// count_q and head already show the state after the stage-1 request
		if (out_free && valid_s1) begin
			popped_q      <= popped_s1;
			dropped_q     <= dropped_s1;
			entry_count_q <= deq_pkg::COUNT_W'(count_q);
			is_empty_q    <= empty;
			front_q       <= empty ? deq_pkg::NEG_ONE : head.f;
			back_q        <= empty ? deq_pkg::NEG_ONE : head.b;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.entry_count  = entry_count_q;
	assign rsp.is_empty     = is_empty_q;
	assign rsp.front_value  = front_q;
	assign rsp.back_value   = back_q;
	assign rsp.push_dropped = dropped_q;

endmodule
`default_nettype wire

// File: sv/deq_checker.sv
`default_nettype none
module deq_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               rsp_valid,
	input wire logic                               rsp_ready,
	input wire logic signed [deq_pkg::DATA_W-1:0]  popped_value,
	input wire logic [deq_pkg::COUNT_W-1:0]        entry_count,
	input wire logic                               is_empty,
	input wire logic signed [deq_pkg::DATA_W-1:0]  front_value,
	input wire logic signed [deq_pkg::DATA_W-1:0]  back_value,
	input wire logic                               push_dropped
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(popped_value)
			&& $stable(entry_count) && $stable(front_value) && $stable(back_value))
		else $error("result changed while stalled");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> is_empty == (entry_count == '0))
		else $error("empty flag disagrees with count");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_empty |-> front_value == deq_pkg::NEG_ONE
			&& back_value == deq_pkg::NEG_ONE)
		else $error("empty queue shows an end value");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> entry_count <= deq_pkg::COUNT_W'(deq_pkg::DEPTH))
		else $error("count above depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && push_dropped |-> entry_count == deq_pkg::COUNT_W'(deq_pkg::DEPTH)
			&& popped_value == deq_pkg::NEG_ONE)
		else $error("push dropped on a queue that is not full");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.popped_value (rsp.popped_value),
	.entry_count  (rsp.entry_count),
	.is_empty     (rsp.is_empty),
	.front_value  (rsp.front_value),
	.back_value   (rsp.back_value),
	.push_dropped (rsp.push_dropped)
);
`default_nettype wire
